FILE: rtl/yuv_pkg.sv
// Shared types, constants and sizes of the planar YUV 4:2:0 to RGB converter.
`default_nettype none

package yuv_pkg;

  localparam int MAX_WIDTH    = 640;
  localparam int MAX_HEIGHT   = 480;
  localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CHROMA_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int LUMA_AW      = $clog2(LUMA_DEPTH);
  localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH + 1);

  // Field widths fixed by the interface
  localparam int HW_W     = 9;
  localparam int HH_W     = 8;
  localparam int ROW_W    = 9;
  localparam int COL_W    = 10;
  localparam int CH_W     = 8;
  localparam int SAMPLE_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 48;

  // Bit positions inside the result tdata
  localparam int TD_ROW_LSB = 0;
  localparam int TD_COL_LSB = TD_ROW_LSB + ROW_W;
  localparam int TD_RED_LSB = TD_COL_LSB + COL_W;
  localparam int TD_GRN_LSB = TD_RED_LSB + CH_W;
  localparam int TD_BLU_LSB = TD_GRN_LSB + CH_W;
  localparam int TD_PAD_W   = M_TDATA_W - (TD_BLU_LSB + CH_W);

  localparam logic [HW_W-1:0] HALF_W_MAX = HW_W'(MAX_WIDTH / 2);
  localparam logic [HH_W-1:0] HALF_H_MAX = HH_W'(MAX_HEIGHT / 2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = CFG_IDX_W'(1);

  // BT.709 coefficients, 16.16 fixed point
  localparam int ACC_W = 28;
  localparam logic signed [18:0] K_Y  = 19'sd76309;
  localparam logic signed [18:0] K_RV = 19'sd117489;
  localparam logic signed [18:0] K_GU = -19'sd13975;
  localparam logic signed [18:0] K_GV = -19'sd34925;
  localparam logic signed [18:0] K_BU = 19'sd138438;
  localparam logic signed [9:0]  Y_OFFSET = 10'sd16;
  localparam logic signed [9:0]  C_OFFSET = 10'sd128;

  localparam logic [1:0] PIX_LAST = 2'd3;

  typedef enum logic [1:0] {
    PLANE_Y,
    PLANE_U,
    PLANE_V
  } plane_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       accept;    // input item taken this cycle
    logic       mult_en;   // form the products of the current pixel
    logic       out_load;  // load the current pixel into the output register
    logic       luma_rd;   // read the luma of the following pixel
    logic [1:0] pix;       // pixel of the 2x2 block in flight
  } cmd_t;

  typedef struct packed {
    plane_e plane;
    logic   out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/yuv_ctrl.sv
// Sequencer: takes items and walks the four pixels of each 2x2 block.
`default_nettype none

module yuv_ctrl import yuv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] pix_q, pix_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pix_q   <= '0;
    end else begin
      state_q <= state_d;
      pix_q   <= pix_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pix_d         = pix_q;
    cmd_o         = '0;
    cmd_o.pix     = pix_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          // a V item starts a block, first luma read goes out now
          if (sts_i.plane == PLANE_V) begin
            pix_d   = '0;
            state_d = ST_MULT;
          end
        end
      end
      ST_MULT: begin
        cmd_o.mult_en = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (pix_q == PIX_LAST) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.luma_rd = 1'b1;
            pix_d         = pix_q + 2'd1;
            state_d       = ST_MULT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/yuv_dp.sv
// Datapath: frame position, luma and chroma stores, BT.709 arithmetic, output register.
`default_nettype none

module yuv_dp import yuv_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic [SAMPLE_W-1:0]  sample_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 m_axis_tready,
  output logic                      m_axis_tvalid,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser
);

  function automatic logic [HW_W-1:0] clamp_hw(input logic [CFG_DAT_W-1:0] v);
    logic [HW_W-1:0] r;
    if (v == '0)              r = HW_W'(1);
    else if (v > HALF_W_MAX)  r = HALF_W_MAX;
    else                      r = HW_W'(v);
    return r;
  endfunction

  function automatic logic [HH_W-1:0] clamp_hh(input logic [CFG_DAT_W-1:0] v);
    logic [HH_W-1:0] r;
    if (v == '0)                           r = HH_W'(1);
    else if (v > CFG_DAT_W'(HALF_H_MAX))   r = HALF_H_MAX;
    else                                   r = HH_W'(v);
    return r;
  endfunction

  // floor shift by 16, then saturate to 0..255
  function automatic logic [CH_W-1:0] shift_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-17:0] s;
    logic [CH_W-1:0]          r;
    s = a[ACC_W-1:16];
    if (s < 0)                       r = '0;
    else if (s > (ACC_W-16)'(255))   r = '1;
    else                             r = s[CH_W-1:0];
    return r;
  endfunction

  // configuration and frame position
  logic [HW_W-1:0]      hw_q;
  logic [HH_W-1:0]      hh_q;
  plane_e               plane_q, plane_d;
  logic [LUMA_AW-1:0]   lin_q, lin_d;
  logic [HW_W-1:0]      bx_q, bx_d;
  logic [HH_W-1:0]      by_q, by_d;
  logic [LUMA_AW-1:0]   base_q, base_d;
  logic [CHROMA_AW-1:0] chroma_len;
  logic [LUMA_AW-1:0]   plane_len;
  logic                 lin_last;
  logic [LUMA_AW-1:0]   width2;
  logic [LUMA_AW-1:0]   p0_addr;

  assign chroma_len = CHROMA_AW'(hw_q) * CHROMA_AW'(hh_q);
  assign plane_len  = (plane_q == PLANE_Y) ? LUMA_AW'({chroma_len, 2'b00})
                                           : LUMA_AW'(chroma_len);
  assign lin_last   = (lin_q == plane_len - LUMA_AW'(1));
  assign width2     = LUMA_AW'({hw_q, 1'b0});
  assign p0_addr    = base_q + LUMA_AW'({bx_q, 1'b0});

  always_comb begin
    plane_d = plane_q;
    lin_d   = lin_q;
    bx_d    = bx_q;
    by_d    = by_q;
    base_d  = base_q;
    if (cmd_i.accept) begin
      if (lin_last) begin
        lin_d = '0;
        case (plane_q)
          PLANE_Y: plane_d = PLANE_U;
          PLANE_U: plane_d = PLANE_V;
          default: plane_d = PLANE_Y;
        endcase
      end else begin
        lin_d = lin_q + LUMA_AW'(1);
      end
      if (plane_q == PLANE_V) begin
        if (lin_last) begin
          bx_d   = '0;
          by_d   = '0;
          base_d = '0;
        end else if (bx_q == hw_q - HW_W'(1)) begin
          bx_d   = '0;
          by_d   = by_q + HH_W'(1);
          base_d = base_q + LUMA_AW'({hw_q, 2'b00});
        end else begin
          bx_d = bx_q + HW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= HALF_W_MAX;
      hh_q    <= HALF_H_MAX;
      plane_q <= PLANE_Y;
      lin_q   <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      base_q  <= '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_HALF_WIDTH ||
                              cfg_index_i == CFG_HALF_HEIGHT)) begin
      // any register write restarts the frame
      if (cfg_index_i == CFG_HALF_WIDTH) hw_q <= clamp_hw(cfg_data_i);
      else                               hh_q <= clamp_hh(cfg_data_i);
      plane_q <= PLANE_Y;
      lin_q   <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      base_q  <= '0;
    end else begin
      plane_q <= plane_d;
      lin_q   <= lin_d;
      bx_q    <= bx_d;
      by_q    <= by_d;
      base_q  <= base_d;
    end
  end

  // block captured when its V item arrives
  logic [SAMPLE_W-1:0] v_q;
  logic [LUMA_AW-1:0]  blk_base_q;
  logic [ROW_W-1:0]    blk_row_q;
  logic [COL_W-1:0]    blk_col_q;
  logic                eof_q;
  logic                v_accept;

  assign v_accept = cmd_i.accept && (plane_q == PLANE_V);

  always_ff @(posedge clk_i) begin
    if (v_accept) begin
      v_q        <= sample_i;
      blk_base_q <= p0_addr;
      blk_row_q  <= ROW_W'({by_q, 1'b0});
      blk_col_q  <= COL_W'({bx_q, 1'b0});
      eof_q      <= lin_last;
    end
  end

  // stores
  logic [SAMPLE_W-1:0] luma_mem [LUMA_DEPTH];
  logic [SAMPLE_W-1:0] chroma_mem [CHROMA_DEPTH];
  logic [SAMPLE_W-1:0] luma_rd_q;
  logic [SAMPLE_W-1:0] chroma_rd_q;
  logic                luma_we, luma_re, chroma_we;
  logic [1:0]          pix_next;
  logic [LUMA_AW-1:0]  next_addr;
  logic [LUMA_AW-1:0]  luma_raddr;

  assign luma_we    = cmd_i.accept && (plane_q == PLANE_Y);
  assign chroma_we  = cmd_i.accept && (plane_q == PLANE_U);
  assign luma_re    = v_accept || cmd_i.luma_rd;
  assign pix_next   = cmd_i.pix + 2'd1;
  assign next_addr  = blk_base_q + (pix_next[1] ? width2 : '0) + LUMA_AW'(pix_next[0]);
  assign luma_raddr = v_accept ? p0_addr : next_addr;

  always_ff @(posedge clk_i) begin
    if (luma_we) begin
      luma_mem[lin_q] <= sample_i;
    end else if (luma_re) begin
      luma_rd_q <= luma_mem[luma_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chroma_we) begin
      chroma_mem[lin_q[CHROMA_AW-1:0]] <= sample_i;
    end else if (v_accept) begin
      chroma_rd_q <= chroma_mem[lin_q[CHROMA_AW-1:0]];
    end
  end

  // products, one register stage
  logic signed [9:0]       y_s, u_s, v_s;
  logic signed [ACC_W-1:0] py_q, pr_q, pgu_q, pgv_q, pb_q;

  assign y_s = $signed({2'b00, luma_rd_q}) - Y_OFFSET;
  assign u_s = $signed({2'b00, chroma_rd_q}) - C_OFFSET;
  assign v_s = $signed({2'b00, v_q}) - C_OFFSET;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult_en) begin
      py_q  <= ACC_W'(y_s) * ACC_W'(K_Y);
      pr_q  <= ACC_W'(v_s) * ACC_W'(K_RV);
      pgu_q <= ACC_W'(u_s) * ACC_W'(K_GU);
      pgv_q <= ACC_W'(v_s) * ACC_W'(K_GV);
      pb_q  <= ACC_W'(u_s) * ACC_W'(K_BU);
    end
  end

  // sums and output register
  logic signed [ACC_W-1:0] r_acc, g_acc, b_acc;
  logic                    out_valid_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic [CH_W-1:0]         red_q, green_q, blue_q;
  logic                    last_q, end_q;

  assign r_acc = py_q + pr_q;
  assign g_acc = py_q + pgu_q + pgv_q;
  assign b_acc = py_q + pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      row_q   <= blk_row_q + ROW_W'(cmd_i.pix[1]);
      col_q   <= blk_col_q + COL_W'(cmd_i.pix[0]);
      red_q   <= shift_sat(r_acc);
      green_q <= shift_sat(g_acc);
      blue_q  <= shift_sat(b_acc);
      last_q  <= (cmd_i.pix == PIX_LAST);
      end_q   <= (cmd_i.pix == PIX_LAST) && eof_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{TD_PAD_W{1'b0}}, blue_q, green_q, red_q, col_q, row_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = end_q;

  assign sts_o.plane    = plane_q;
  assign sts_o.out_free = !out_valid_q || m_axis_tready;

endmodule

`default_nettype wire

FILE: rtl/yuv420_planar_to_rgb_core.sv
// Top level: planar YUV 4:2:0 frame stream in, BT.709 RGB pixels out.
//
// Input stream (s_axis): one byte per item, the Y plane, then U, then V, each in
// raster order. Y and U items are stored without holding the input. A V item
// completes a 2x2 block and yields four pixels (top-left, top-right, bottom-left,
// bottom-right) on m_axis; tlast marks the fourth pixel of the block and tuser
// the final pixel of the frame.
// The first pixel of a block goes through the store read registers, the product
// registers and the output register after its V item. A V item holds the input
// until its four pixels are loaded, since the single luma read port runs the read,
// multiply, sum sequence once per pixel. The last pixel waits in the output
// register while the next items are taken.
// A receiver stall holds the current pixel and the block sequence waits; no
// item is dropped.
// Config port: index 0 is half width (1..320), index 1 is half height (1..240);
// out-of-range values saturate and a write to either register restarts the
// frame. Write only while idle.
// Reset: frame position returns to the first Y byte, size to 640x480. The stores
// are not cleared.
`default_nettype none

module yuv420_planar_to_rgb_core import yuv_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] sample
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [8:0] row, [18:9] col, [26:19] red, [34:27] green, [42:35] blue, rest zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser,   // [0] end_of_frame
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  yuv_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  yuv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (s_axis_tdata[SAMPLE_W-1:0]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/yuv_chk.sv
// Port-level checks of the converter, bound to the top level.
`default_nettype none

module yuv_chk import yuv_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast,
  input wire logic                 m_axis_tuser
);

  // frame end only on the closing pixel of a block
  a_eof_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end_of_frame without last_of_block");

  // the closing pixel of a block sits on odd row and odd column
  a_last_is_br: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[TD_ROW_LSB] && m_axis_tdata[TD_COL_LSB])
    else $error("block end not at bottom-right pixel");

  // no new item while a block is half emitted
  a_block_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a block");

  // hold a stalled pixel
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled pixel changed");

endmodule

bind yuv420_planar_to_rgb_core yuv_chk u_yuv_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: bench/yuv_rgb_checker.sv
// Scoreboard for the YUV 4:2:0 to RGB core: mirrors the frame and checks every RGB item.
`timescale 1ns / 1ps

module yuv_rgb_checker import yuv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [M_TDATA_W-1:0] m_data_i,
  input  logic                 m_last_i,
  input  logic                 m_user_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last_blk;
    logic             eof;
  } rgb_pixel_t;

  logic [SAMPLE_W-1:0] luma_mem  [LUMA_DEPTH];
  logic [SAMPLE_W-1:0] udiff_mem [CHROMA_DEPTH];
  int                  frame_pos;
  int                  half_w;
  int                  half_h;
  rgb_pixel_t          expected_pixels [$];

  function automatic int fit_half(int val, int hi);
    if (val < 1) return 1;
    if (val > hi) return hi;
    return val;
  endfunction

  // Floor shift out the 16 fraction bits, then saturate.
  function automatic logic [CH_W-1:0] to_channel(longint acc);
    longint s;
    s = acc >>> 16;
    if (s < 0) return '0;
    if (s > 255) return '1;
    return CH_W'(s);
  endfunction

  function automatic string pixel_text(rgb_pixel_t px);
    return $sformatf("row %0d col %0d rgb %0d/%0d/%0d last %0b eof %0b",
                     px.row, px.col, px.red, px.green, px.blue, px.last_blk, px.eof);
  endfunction

  task automatic take_frame_byte(input logic [SAMPLE_W-1:0] smp);
    int         w, chroma_len, luma_len, total, pos, k, blk_row, blk_col, r, c, p;
    longint     u, v, y;
    plane_e     plane;
    rgb_pixel_t px;
    w          = 2 * half_w;
    chroma_len = half_w * half_h;
    luma_len   = 4 * chroma_len;
    total      = luma_len + 2 * chroma_len;
    pos        = (frame_pos >= total) ? 0 : frame_pos;
    if (pos < luma_len) plane = PLANE_Y;
    else if (pos < luma_len + chroma_len) plane = PLANE_U;
    else plane = PLANE_V;
    case (plane)
      PLANE_Y: luma_mem[pos] = smp;
      PLANE_U: udiff_mem[pos - luma_len] = smp;
      default: begin
        k       = pos - luma_len - chroma_len;
        blk_row = k / half_w;
        blk_col = k % half_w;
        u = longint'(udiff_mem[k]) - longint'(C_OFFSET);
        v = longint'(smp) - longint'(C_OFFSET);
        // chroma of the block is shared by its four pixels, raster order
        for (p = 0; p < 4; p++) begin
          r = 2 * blk_row + p / 2;
          c = 2 * blk_col + p % 2;
          y = (longint'(luma_mem[r * w + c]) - longint'(Y_OFFSET)) * longint'(K_Y);
          px.row      = ROW_W'(r);
          px.col      = COL_W'(c);
          px.red      = to_channel(y + v * longint'(K_RV));
          px.green    = to_channel(y + u * longint'(K_GU) + v * longint'(K_GV));
          px.blue     = to_channel(y + u * longint'(K_BU));
          px.last_blk = (p == 3);
          px.eof      = (p == 3) && (pos + 1 == total);
          expected_pixels.push_back(px);
        end
      end
    endcase
    pos++;
    frame_pos = (pos >= total) ? 0 : pos;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_pixel_t got;
    rgb_pixel_t want;
    if (!rst_ni) begin
      frame_pos = 0;
      half_w    = int'(HALF_W_MAX);
      half_h    = int'(HALF_H_MAX);
      expected_pixels.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HALF_WIDTH: begin
            half_w    = fit_half(int'(cfg_data_i), int'(HALF_W_MAX));
            frame_pos = 0;
          end
          CFG_HALF_HEIGHT: begin
            half_h    = fit_half(int'(cfg_data_i), int'(HALF_H_MAX));
            frame_pos = 0;
          end
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) take_frame_byte(s_data_i[SAMPLE_W-1:0]);
      if (m_valid_i && m_ready_i) begin
        got.row      = m_data_i[TD_ROW_LSB +: ROW_W];
        got.col      = m_data_i[TD_COL_LSB +: COL_W];
        got.red      = m_data_i[TD_RED_LSB +: CH_W];
        got.green    = m_data_i[TD_GRN_LSB +: CH_W];
        got.blue     = m_data_i[TD_BLU_LSB +: CH_W];
        got.last_blk = m_last_i;
        got.eof      = m_user_i;
        checked_o++;
        if (expected_pixels.size() == 0) begin
          errors_o++;
          $display("%0t: RGB item with none pending: expected nothing, actual %s",
                   $time, pixel_text(got));
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want || m_data_i[M_TDATA_W-1 -: TD_PAD_W] !== '0) begin
            errors_o++;
            $display("%0t: RGB mismatch: expected %s, actual %s pad %h", $time,
                     pixel_text(want), pixel_text(got), m_data_i[M_TDATA_W-1 -: TD_PAD_W]);
          end
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

FILE: bench/tb.sv
// Top of the YUV 4:2:0 to RGB bench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import yuv_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 160;
  // indexes past the two registers, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  int errors, pending, checked;
  int idle_cycles;
  bit quiet;
  int tx_calm;
  int cur_hw, cur_hh, frame_len, frame_fill;
  int samples_sent, frames_done, reg_writes;

  yuv420_planar_to_rgb_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  yuv_rgb_checker rgb_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_last_i    (m_axis_tlast),
    .m_user_i    (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stall bursts, calm stretches, none once quiet.
  initial begin
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm > 0) calm--;
        else if (!quiet && $urandom_range(0, 29) == 0) calm = $urandom_range(20, 60);
        else if (!quiet && $urandom_range(0, 3) == 0) stall = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d RGB items outstanding",
               $time, IDLE_LIMIT, pending);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int fit_half(int val, int hi);
    if (val < 1) return 1;
    if (val > hi) return hi;
    return val;
  endfunction

  function automatic logic [S_TDATA_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return S_TDATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_sample(input logic [S_TDATA_W-1:0] smp);
    @(negedge clk_i);
    if (!quiet && tx_calm == 0 && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end else if (tx_calm > 0) begin
      tx_calm--;
    end else if (!quiet && $urandom_range(0, 39) == 0) begin
      tx_calm = $urandom_range(15, 50);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
    frame_fill++;
    if (frame_fill == frame_len) begin
      frame_fill = 0;
      frames_done++;
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(rand_sample());
  endtask

  // Drain all pending RGB items, then let a trailing V item finish.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    wait_idle();
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_HALF_WIDTH: begin
        cur_hw     = fit_half(int'(val), int'(HALF_W_MAX));
        frame_fill = 0;
      end
      CFG_HALF_HEIGHT: begin
        cur_hh     = fit_half(int'(val), int'(HALF_H_MAX));
        frame_fill = 0;
      end
      default: ;
    endcase
    frame_len = 6 * cur_hw * cur_hh;
  endtask

  initial begin
    // 2x2 frames: Y00 Y01 Y10 Y11 U V
    static logic [S_TDATA_W-1:0] pattern [24] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd16,  8'd235, 8'd0,   8'd255, 8'd0,   8'd255,
      8'd255, 8'd0,   8'd128, 8'd16,  8'd255, 8'd0
    };
    int random_sent;
    int n;
    bit rewrite;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_HALF_WIDTH;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    tx_calm       = 0;
    cur_hw        = int'(HALF_W_MAX);
    cur_hh        = int'(HALF_H_MAX);
    frame_len     = 6 * cur_hw * cur_hh;
    frame_fill    = 0;
    samples_sent  = 0;
    frames_done   = 0;
    reg_writes    = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // a few luma bytes at the reset size, then shrink to one block
    send_random(2);
    write_reg(CFG_HALF_WIDTH, 1);
    write_reg(CFG_HALF_HEIGHT, 1);
    for (int i = 0; i < 3; i++) send_sample(pattern[i]);
    write_reg(CFG_SPARE_A, '1);
    for (int i = 3; i < 24; i++) send_sample(pattern[i]);

    // zero register values saturate to one block
    write_reg(CFG_HALF_WIDTH, 0);
    write_reg(CFG_HALF_HEIGHT, 0);
    send_random(frame_len);
    write_reg(CFG_SPARE_B, '0);
    // too large values saturate to the top size; cut that frame short
    write_reg(CFG_HALF_WIDTH, '1);
    write_reg(CFG_HALF_HEIGHT, '1);
    send_random(8);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= RANDOM_ITEMS * 3 / 4) quiet = 1'b1;
      rewrite = (frame_fill != 0) || ($urandom_range(0, 1) == 0);
      if (rewrite) begin
        if ($urandom_range(0, 7) == 0) begin
          write_reg(CFG_HALF_WIDTH, CFG_DAT_W'($urandom_range(5, 12)));
          write_reg(CFG_HALF_HEIGHT, 1);
        end else begin
          write_reg(CFG_HALF_WIDTH, CFG_DAT_W'($urandom_range(1, 4)));
          if ($urandom_range(0, 1) == 0 || cur_hw * cur_hh > 12)
            write_reg(CFG_HALF_HEIGHT, CFG_DAT_W'($urandom_range(1, 3)));
        end
      end
      // mostly whole frames; now and then cut one short and restart
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, frame_len - 1);
      else n = frame_len * $urandom_range(1, 2);
      send_random(n);
      random_sent += n;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("summary: %0d samples, %0d whole frames, %0d register writes, %0d RGB items checked",
             samples_sent, frames_done, reg_writes, checked);
    $display("summary: block sizes 1x1 to 12x3, saturated channels and registers, restarts");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
